[rtl/fvrw_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fvrw_pkg
// Shared types, command codes and lookup tables of the FM voice register writer.
// ----------------------------------------------------------------------------
package fvrw_pkg;

  // command codes
  localparam logic [1:0] REQ_FREQ = 2'd0;
  localparam logic [1:0] REQ_VOL  = 2'd1;
  localparam logic [1:0] REQ_PAN  = 2'd2;

  // channel layout
  localparam logic [4:0] NUM_CHANNELS = 5'd18;
  localparam logic [4:0] BANK_SLOTS   = 5'd9;

  // register bases and data constants
  localparam logic [7:0] BASE_FREQ_LO = 8'hA0;
  localparam logic [7:0] BASE_FREQ_HI = 8'hB0;
  localparam logic [7:0] BASE_LEVEL   = 8'h40;
  localparam logic [7:0] BASE_PAN     = 8'hC0;
  localparam logic [7:0] OP2_STEP     = 8'd3;
  localparam logic [5:0] LEVEL_MAX    = 6'h3F;
  localparam logic [6:0] LOUD_MAX     = 7'd127;
  localparam logic [7:0] PAN_LEFT     = 8'h10;
  localparam logic [7:0] PAN_RIGHT    = 8'h20;
  localparam logic [7:0] PAN_CENTER   = 8'h30;
  localparam logic signed [6:0] PAN_THRESH_LO = -7'sd36;
  localparam logic signed [6:0] PAN_THRESH_HI = 7'sd36;

  // loudness curve, 0..127 in, 0..127 out
  localparam logic [6:0] VOL_CURVE [128] = '{
    7'd0,   7'd1,   7'd3,   7'd5,   7'd6,   7'd8,   7'd10,  7'd11,
    7'd13,  7'd14,  7'd16,  7'd17,  7'd19,  7'd20,  7'd22,  7'd23,
    7'd25,  7'd26,  7'd27,  7'd29,  7'd30,  7'd32,  7'd33,  7'd34,
    7'd36,  7'd37,  7'd39,  7'd41,  7'd43,  7'd45,  7'd47,  7'd49,
    7'd50,  7'd52,  7'd54,  7'd55,  7'd57,  7'd59,  7'd60,  7'd61,
    7'd63,  7'd64,  7'd66,  7'd67,  7'd68,  7'd69,  7'd71,  7'd72,
    7'd73,  7'd74,  7'd75,  7'd76,  7'd77,  7'd79,  7'd80,  7'd81,
    7'd82,  7'd83,  7'd84,  7'd84,  7'd85,  7'd86,  7'd87,  7'd88,
    7'd89,  7'd90,  7'd91,  7'd92,  7'd92,  7'd93,  7'd94,  7'd95,
    7'd96,  7'd96,  7'd97,  7'd98,  7'd99,  7'd99,  7'd100, 7'd101,
    7'd101, 7'd102, 7'd103, 7'd103, 7'd104, 7'd105, 7'd105, 7'd106,
    7'd107, 7'd107, 7'd108, 7'd109, 7'd109, 7'd110, 7'd110, 7'd111,
    7'd112, 7'd112, 7'd113, 7'd113, 7'd114, 7'd114, 7'd115, 7'd115,
    7'd116, 7'd117, 7'd117, 7'd118, 7'd118, 7'd119, 7'd119, 7'd120,
    7'd120, 7'd121, 7'd121, 7'd122, 7'd122, 7'd123, 7'd123, 7'd123,
    7'd124, 7'd124, 7'd125, 7'd125, 7'd126, 7'd126, 7'd127, 7'd127
  };

  // operator register offset for each slot of a bank
  localparam logic [4:0] OP_OFFSET [9] = '{
    5'h00, 5'h01, 5'h02, 5'h08, 5'h09, 5'h0A, 5'h10, 5'h11, 5'h12
  };

  // one voice command
  typedef struct packed {
    logic [1:0]        req_type;
    logic [4:0]        channel;
    logic [9:0]        fnum;
    logic [2:0]        octave;
    logic              key_on;
    logic [7:0]        loudness;
    logic signed [6:0] balance;
    logic [5:0]        op1_level;
    logic [7:0]        op1_scale;
    logic [5:0]        op2_level;
    logic [7:0]        op2_scale;
    logic [7:0]        fb_conn;
  } item_t;

  // one register write
  typedef struct packed {
    logic       chip_sel;
    logic [7:0] reg_addr;
    logic [7:0] reg_data;
    logic       last;
  } write_t;

  // writes produced by one command
  typedef struct packed {
    logic [1:0] count;
    write_t     first;
    write_t     second;
  } writes_t;

endpackage : fvrw_pkg
`default_nettype wire

[rtl/fvrw_scale.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fvrw_scale
// Scales one operator attenuation level by the loudness curve.
// ----------------------------------------------------------------------------
module fvrw_scale (
  input  wire logic [5:0] level,
  input  wire logic [6:0] curve,
  output logic      [5:0] scaled
);
  import fvrw_pkg::*;

  logic [5:0]  headroom;
  logic [12:0] product;

  // level = max - ((max - level) * curve >> 7)
  always_comb begin
    headroom = LEVEL_MAX - level;
    product  = 13'(headroom) * 13'(curve);
    scaled   = LEVEL_MAX - product[12:7];
  end

endmodule : fvrw_scale
`default_nettype wire

[rtl/fvrw_calc.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fvrw_calc
// Maps one registered voice command to its register writes.
// ----------------------------------------------------------------------------
module fvrw_calc (
  input  wire fvrw_pkg::item_t   item,
  output fvrw_pkg::writes_t      writes
);
  import fvrw_pkg::*;

  logic       in_range;
  logic       bank;
  logic [3:0] slot;
  logic [7:0] slot_b;
  logic [6:0] vol;
  logic [6:0] curve;
  logic [5:0] op1_scaled;
  logic [5:0] op2_scaled;
  logic [5:0] op1_final;
  logic [7:0] op_addr;
  logic [7:0] pan_bits;

  // bank and slot from channel
  always_comb begin
    in_range = item.channel < NUM_CHANNELS;
    bank     = item.channel >= BANK_SLOTS;
    slot     = bank ? 4'(item.channel - BANK_SLOTS) : item.channel[3:0];
    slot_b   = 8'(slot);
  end

  // loudness saturation and curve lookup
  always_comb begin
    vol   = item.loudness[7] ? LOUD_MAX : item.loudness[6:0];
    curve = VOL_CURVE[vol];
  end

  fvrw_scale u_scale_op1 (
    .level  (item.op1_level),
    .curve  (curve),
    .scaled (op1_scaled)
  );

  fvrw_scale u_scale_op2 (
    .level  (item.op2_level),
    .curve  (curve),
    .scaled (op2_scaled)
  );

  // operator 1 scaled only for additive connection
  always_comb begin
    op1_final = item.fb_conn[0] ? op1_scaled : item.op1_level;
    op_addr   = BASE_LEVEL + 8'(OP_OFFSET[slot < 4'd9 ? slot : 4'd0]);
  end

  // stereo bits from balance
  always_comb begin
    if (item.balance < PAN_THRESH_LO) begin
      pan_bits = PAN_LEFT;
    end else if (item.balance > PAN_THRESH_HI) begin
      pan_bits = PAN_RIGHT;
    end else begin
      pan_bits = PAN_CENTER;
    end
  end

  // assemble writes per command
  always_comb begin
    writes = '0;
    writes.first.chip_sel  = bank;
    writes.second.chip_sel = bank;
    writes.second.last     = 1'b1;
    unique case (item.req_type)
      REQ_FREQ: begin
        writes.count           = in_range ? 2'd2 : 2'd0;
        writes.first.reg_addr  = BASE_FREQ_LO + slot_b;
        writes.first.reg_data  = item.fnum[7:0];
        writes.second.reg_addr = BASE_FREQ_HI + slot_b;
        writes.second.reg_data = {2'b00, item.key_on, item.octave, item.fnum[9:8]};
      end
      REQ_VOL: begin
        writes.count           = in_range ? 2'd2 : 2'd0;
        writes.first.reg_addr  = op_addr;
        writes.first.reg_data  = {2'b00, op1_final} | item.op1_scale;
        writes.second.reg_addr = op_addr + OP2_STEP;
        writes.second.reg_data = {2'b00, op2_scaled} | item.op2_scale;
      end
      REQ_PAN: begin
        writes.count          = in_range ? 2'd1 : 2'd0;
        writes.first.reg_addr = BASE_PAN + slot_b;
        writes.first.reg_data = item.fb_conn | pan_bits;
        writes.first.last     = 1'b1;
      end
      default: begin
        writes.count = 2'd0;
      end
    endcase
  end

endmodule : fvrw_calc
`default_nettype wire

[rtl/fm_voice_register_writer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fm_voice_register_writer
// Turns voice commands for 18 FM channels into register writes.
// ----------------------------------------------------------------------------
// Each accepted item is held in an input register; the register writes are
// computed from it in one pass and handed to an output register, one write per
// cycle while the receiver is ready, with the second write of a command parked
// in a one-entry holding register. Frequency and volume commands produce two
// writes, pan commands one, and out-of-range channels or unknown commands are
// taken and produce no write. The single output port, one write per cycle while
// the receiver is ready, sets the pace at which commands are taken.
module fm_voice_register_writer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  req_type,
  input  wire logic [4:0]  channel,
  input  wire logic [9:0]  fnum,
  input  wire logic [2:0]  octave,
  input  wire logic        key_on,
  input  wire logic [7:0]  loudness,
  input  wire logic signed [6:0] balance,
  input  wire logic [5:0]  op1_level,
  input  wire logic [7:0]  op1_scale,
  input  wire logic [5:0]  op2_level,
  input  wire logic [7:0]  op2_scale,
  input  wire logic [7:0]  fb_conn,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             chip_sel,
  output logic [7:0]       reg_addr,
  output logic [7:0]       reg_data,
  output logic             last
);
  import fvrw_pkg::*;

  item_t   item;
  logic    item_valid;
  writes_t writes;
  write_t  pend;
  logic    pend_valid;
  write_t  result;
  logic    result_valid;

  logic    out_free;
  logic    item_take;
  logic    out_load;
  write_t  out_next;
  logic    pend_set;

  fvrw_calc u_calc (
    .item   (item),
    .writes (writes)
  );

  // handoff between input register, holding register and output register
  always_comb begin
    out_free  = !result_valid || out_ready;
    item_take = 1'b0;
    out_load  = 1'b0;
    out_next  = pend;
    pend_set  = 1'b0;
    if (pend_valid) begin
      out_load = out_free;
    end else if (item_valid) begin
      if (writes.count == 2'd0) begin
        item_take = 1'b1;
      end else if (out_free) begin
        item_take = 1'b1;
        out_load  = 1'b1;
        out_next  = writes.first;
        pend_set  = writes.count == 2'd2;
      end
    end
    in_ready = !item_valid || item_take;
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= '{req_type, channel, fnum, octave, key_on, loudness, balance,
                op1_level, op1_scale, op2_level, op2_scale, fb_conn};
    end
  end

  // holding register for the second write
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (pend_valid && out_free) begin
      pend_valid <= 1'b0;
    end else if (pend_set) begin
      pend_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_set) begin
      pend <= writes.second;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= out_load;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result <= out_next;
    end
  end

  assign out_valid = result_valid;
  assign chip_sel  = result.chip_sel;
  assign reg_addr  = result.reg_addr;
  assign reg_data  = result.reg_data;
  assign last      = result.last;

endmodule : fm_voice_register_writer
`default_nettype wire

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Testbench of the FM voice register writer.
// Commands are sent over the input handshake, and a local model turns each
// accepted command into the register writes it should cause. Each write that
// leaves the block is compared field by field with the oldest expected write.
// Directed commands cover the field extremes, every command and the ignored
// cases. Random traffic then runs with changing idle rates on both sides, a
// long receiver hold-off and a sender pause.
// ----------------------------------------------------------------------------
module tb;
  import fvrw_pkg::*;

  // command code that the block does not know
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_LEN    = 300;
  localparam int TAIL_CYCLES = 8;

  // loudness curve, kept apart from the design's copy
  localparam logic [6:0] LOUD_CURVE [128] = '{
    7'd0,   7'd1,   7'd3,   7'd5,   7'd6,   7'd8,   7'd10,  7'd11,
    7'd13,  7'd14,  7'd16,  7'd17,  7'd19,  7'd20,  7'd22,  7'd23,
    7'd25,  7'd26,  7'd27,  7'd29,  7'd30,  7'd32,  7'd33,  7'd34,
    7'd36,  7'd37,  7'd39,  7'd41,  7'd43,  7'd45,  7'd47,  7'd49,
    7'd50,  7'd52,  7'd54,  7'd55,  7'd57,  7'd59,  7'd60,  7'd61,
    7'd63,  7'd64,  7'd66,  7'd67,  7'd68,  7'd69,  7'd71,  7'd72,
    7'd73,  7'd74,  7'd75,  7'd76,  7'd77,  7'd79,  7'd80,  7'd81,
    7'd82,  7'd83,  7'd84,  7'd84,  7'd85,  7'd86,  7'd87,  7'd88,
    7'd89,  7'd90,  7'd91,  7'd92,  7'd92,  7'd93,  7'd94,  7'd95,
    7'd96,  7'd96,  7'd97,  7'd98,  7'd99,  7'd99,  7'd100, 7'd101,
    7'd101, 7'd102, 7'd103, 7'd103, 7'd104, 7'd105, 7'd105, 7'd106,
    7'd107, 7'd107, 7'd108, 7'd109, 7'd109, 7'd110, 7'd110, 7'd111,
    7'd112, 7'd112, 7'd113, 7'd113, 7'd114, 7'd114, 7'd115, 7'd115,
    7'd116, 7'd117, 7'd117, 7'd118, 7'd118, 7'd119, 7'd119, 7'd120,
    7'd120, 7'd121, 7'd121, 7'd122, 7'd122, 7'd123, 7'd123, 7'd123,
    7'd124, 7'd124, 7'd125, 7'd125, 7'd126, 7'd126, 7'd127, 7'd127
  };

  // operator register offset per slot
  localparam logic [7:0] SLOT_OP_OFFSET [9] = '{
    8'h00, 8'h01, 8'h02, 8'h08, 8'h09, 8'h0A, 8'h10, 8'h11, 8'h12
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        req_type = '0;
  logic [4:0]        channel = '0;
  logic [9:0]        fnum = '0;
  logic [2:0]        octave = '0;
  logic              key_on = 1'b0;
  logic [7:0]        loudness = '0;
  logic signed [6:0] balance = '0;
  logic [5:0]        op1_level = '0;
  logic [7:0]        op1_scale = '0;
  logic [5:0]        op2_level = '0;
  logic [7:0]        op2_scale = '0;
  logic [7:0]        fb_conn = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              chip_sel;
  logic [7:0]        reg_addr;
  logic [7:0]        reg_data;
  logic              last;

  write_t expected_writes [$];
  int     mismatch_count = 0;
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  int     hold_requests = 0;
  int     holds_done = 0;
  int     hold_count = 0;
  int     quiet_cycles = 0;

  fm_voice_register_writer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .channel   (channel),
    .fnum      (fnum),
    .octave    (octave),
    .key_on    (key_on),
    .loudness  (loudness),
    .balance   (balance),
    .op1_level (op1_level),
    .op1_scale (op1_scale),
    .op2_level (op2_level),
    .op2_scale (op2_scale),
    .fb_conn   (fb_conn),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .chip_sel  (chip_sel),
    .reg_addr  (reg_addr),
    .reg_data  (reg_data),
    .last      (last)
  );

  always #10 clk = ~clk;

  // operator level after loudness scaling
  function automatic logic [5:0] scaled_level(input logic [5:0] lvl, input logic [7:0] loud);
    logic [6:0]  v;
    logic [12:0] prod;
    v = (loud > 8'd127) ? LOUD_MAX : loud[6:0];
    prod = 13'(LEVEL_MAX - lvl) * 13'(LOUD_CURVE[v]);
    return LEVEL_MAX - prod[12:7];
  endfunction

  // queue the register writes that one command must produce
  function automatic void predict_writes(input item_t cmd);
    logic              bank;
    logic [3:0]        slot;
    logic [7:0]        addr;
    logic [5:0]        lvl1;
    logic [5:0]        lvl2;
    logic signed [6:0] pan;
    logic [7:0]        pan_bits;
    if (cmd.channel >= NUM_CHANNELS) return;
    bank = (cmd.channel >= BANK_SLOTS);
    slot = bank ? 4'(cmd.channel - BANK_SLOTS) : cmd.channel[3:0];
    case (cmd.req_type)
      REQ_FREQ: begin
        expected_writes.push_back(write_t'{bank, BASE_FREQ_LO + 8'(slot), cmd.fnum[7:0],
                                  1'b0});
        expected_writes.push_back(write_t'{bank, BASE_FREQ_HI + 8'(slot),
                                  {2'b00, cmd.key_on, cmd.octave, cmd.fnum[9:8]}, 1'b1});
      end
      REQ_VOL: begin
        addr = BASE_LEVEL + SLOT_OP_OFFSET[slot];
        // operator 1 is only scaled in additive connection
        lvl1 = cmd.fb_conn[0] ? scaled_level(cmd.op1_level, cmd.loudness) : cmd.op1_level;
        lvl2 = scaled_level(cmd.op2_level, cmd.loudness);
        expected_writes.push_back(write_t'{bank, addr, {2'b00, lvl1} | cmd.op1_scale, 1'b0});
        expected_writes.push_back(write_t'{bank, addr + OP2_STEP,
                                  {2'b00, lvl2} | cmd.op2_scale, 1'b1});
      end
      REQ_PAN: begin
        pan = cmd.balance;
        if (pan < PAN_THRESH_LO) pan_bits = PAN_LEFT;
        else if (pan > PAN_THRESH_HI) pan_bits = PAN_RIGHT;
        else pan_bits = PAN_CENTER;
        expected_writes.push_back(write_t'{bank, BASE_PAN + 8'(slot), cmd.fb_conn | pan_bits,
                                  1'b1});
      end
      default: begin
      end
    endcase
  endfunction

  // random command, mostly known codes on valid channels
  function automatic item_t random_command();
    logic [95:0] bits;
    item_t       c;
    int          pick;
    bits = {$urandom(), $urandom(), $urandom()};
    c = bits[71:0];
    pick = $urandom_range(0, 19);
    if (pick == 0) c.req_type = REQ_UNUSED;
    else if (pick < 7) c.req_type = REQ_FREQ;
    else if (pick < 13) c.req_type = REQ_VOL;
    else c.req_type = REQ_PAN;
    if ($urandom_range(0, 15) == 0) c.channel = 5'($urandom_range(18, 31));
    else c.channel = 5'($urandom_range(0, 17));
    return c;
  endfunction

  // offer one item and wait until it is taken
  task automatic send_item(input item_t c);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    req_type  <= c.req_type;
    channel   <= c.channel;
    fnum      <= c.fnum;
    octave    <= c.octave;
    key_on    <= c.key_on;
    loudness  <= c.loudness;
    balance   <= c.balance;
    op1_level <= c.op1_level;
    op1_scale <= c.op1_scale;
    op2_level <= c.op2_level;
    op2_scale <= c.op2_scale;
    fb_conn   <= c.fb_conn;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop sending until every expected write has come out
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_writes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic test_frequency();
    item_t c;
    c = random_command();
    c.req_type = REQ_FREQ;
    c.channel = 5'd0; c.fnum = 10'd0; c.octave = 3'd0; c.key_on = 1'b0;
    send_item(c);
    c.channel = 5'd8; c.fnum = 10'd1023; c.octave = 3'd7; c.key_on = 1'b1;
    send_item(c);
    c.channel = 5'd9; c.fnum = 10'h155; c.octave = 3'd5; c.key_on = 1'b1;
    send_item(c);
    c.channel = 5'd17; c.fnum = 10'h2AA; c.octave = 3'd2; c.key_on = 1'b0;
    send_item(c);
  endtask

  task automatic test_volume();
    item_t c;
    c = random_command();
    c.req_type = REQ_VOL;
    c.channel = 5'd0; c.loudness = 8'd0; c.fb_conn = 8'h01;
    c.op1_level = 6'd0; c.op2_level = 6'd63; c.op1_scale = 8'h00; c.op2_scale = 8'h00;
    send_item(c);
    c.channel = 5'd4; c.loudness = 8'd127; c.op1_level = 6'd63; c.op2_level = 6'd0;
    send_item(c);
    // loudness above the curve saturates
    c.channel = 5'd12; c.loudness = 8'd128; c.fb_conn = 8'hFE;
    send_item(c);
    c.channel = 5'd17; c.loudness = 8'd255; c.fb_conn = 8'hFF;
    c.op1_scale = 8'hFF; c.op2_scale = 8'hFF;
    send_item(c);
    c.channel = 5'd8; c.loudness = 8'd64; c.fb_conn = 8'h00;
    c.op1_level = 6'd21; c.op2_level = 6'd42; c.op1_scale = 8'h40; c.op2_scale = 8'h80;
    send_item(c);
    c.channel = 5'd15; c.fb_conn = 8'h01;
    send_item(c);
  endtask

  task automatic test_pan();
    item_t c;
    c = random_command();
    c.req_type = REQ_PAN;
    c.fb_conn = 8'h00;
    c.channel = 5'd0;  c.balance = -7'sd64; send_item(c);
    c.channel = 5'd3;  c.balance = -7'sd37; send_item(c);
    c.channel = 5'd8;  c.balance = -7'sd36; send_item(c);
    c.fb_conn = 8'hFF;
    c.channel = 5'd9;  c.balance = 7'sd0;   send_item(c);
    c.channel = 5'd11; c.balance = 7'sd36;  send_item(c);
    c.channel = 5'd16; c.balance = 7'sd37;  send_item(c);
    c.channel = 5'd17; c.balance = 7'sd63;  send_item(c);
  endtask

  // unknown command and out-of-range channels give no writes
  task automatic test_ignored();
    item_t c;
    c = random_command();
    c.req_type = REQ_UNUSED; c.channel = 5'd0;  send_item(c);
    c.req_type = REQ_FREQ;   c.channel = 5'd18; send_item(c);
    c.req_type = REQ_VOL;    c.channel = 5'd31; send_item(c);
    c.req_type = REQ_PAN;    c.channel = 5'd24; send_item(c);
    // a valid command right after the ignored ones
    c.req_type = REQ_FREQ;   c.channel = 5'd1;  send_item(c);
  endtask

  task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) send_item(random_command());
  endtask

  // receiver holds off while the sender keeps offering items
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests = hold_requests + 1;
    repeat (40) send_item(random_command());
  endtask

  // sender pauses until the block has emptied, then resumes
  task automatic test_sender_pause();
    send_idle_pct = 10;
    recv_idle_pct = 10;
    repeat (10) send_item(random_command());
    wait_drain();
    repeat (10) send_item(random_command());
  endtask

  // receiver ready, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_count != 0) begin
      out_ready <= 1'b0;
      hold_count <= hold_count - 1;
    end else if (holds_done != hold_requests) begin
      out_ready <= 1'b0;
      hold_count <= HOLD_LEN - 1;
      holds_done <= holds_done + 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // predict on input items, check output items, watch for a stall
  always @(posedge clk) begin : monitor
    item_t  cmd;
    write_t exp_w;
    if (!rst) begin
      if (in_valid && in_ready) begin
        cmd = '{req_type, channel, fnum, octave, key_on, loudness, balance,
                op1_level, op1_scale, op2_level, op2_scale, fb_conn};
        predict_writes(cmd);
      end
      if (out_valid && out_ready) begin
        if (expected_writes.size() == 0) begin
          $display("%0t: unexpected write chip_sel %h reg_addr %h reg_data %h last %h",
                   $time, chip_sel, reg_addr, reg_data, last);
          mismatch_count = mismatch_count + 1;
        end else begin
          exp_w = expected_writes.pop_front();
          if (chip_sel !== exp_w.chip_sel) begin
            $display("%0t: chip_sel expected %h actual %h", $time, exp_w.chip_sel, chip_sel);
            mismatch_count = mismatch_count + 1;
          end
          if (reg_addr !== exp_w.reg_addr) begin
            $display("%0t: reg_addr expected %h actual %h", $time, exp_w.reg_addr, reg_addr);
            mismatch_count = mismatch_count + 1;
          end
          if (reg_data !== exp_w.reg_data) begin
            $display("%0t: reg_data expected %h actual %h", $time, exp_w.reg_data, reg_data);
            mismatch_count = mismatch_count + 1;
          end
          if (last !== exp_w.last) begin
            $display("%0t: last expected %h actual %h", $time, exp_w.last, last);
            mismatch_count = mismatch_count + 1;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
          $display("Mismatches found");
          $finish;
        end
      end
    end
  end

  // test sequence
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 18;
    recv_idle_pct = 53;
    test_frequency();
    test_volume();
    test_pan();
    test_ignored();
    test_random_traffic(550, 18, 53);
    test_random_traffic(550, 53, 18);
    test_random_traffic(550, 0, 0);
    test_backpressure();
    test_sender_pause();
    wait_drain();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/fvrw_pkg.sv
rtl/fvrw_scale.sv
rtl/fvrw_calc.sv
rtl/fm_voice_register_writer.sv
verif/tb.sv
